// ----- hw/rtl/otq_pkg.sv -----
`timescale 1ns / 1ps
package otq_pkg;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_DEL    = 2'd1;
    localparam logic [1:0] MODE_HANDLE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EXPIRED  = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic [23:0] delay_ms;
        logic [7:0]  timer_id;
        logic [32:0] del_expire;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  fired_id;
        logic [32:0] fired_expire;
        logic [32:0] sleep_ms;
        logic        queue_empty;
        logic        last;
    } t_out;

    typedef struct packed {
        logic       load_in;
        logic       do_add;
        logic       del_step;
        logic       pop;
        logic       calc_sleep;
        logic       sleep_at_cnt;
        logic       out_load;
        logic [2:0] out_status;
        logic       out_fired;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic any_match;
        logic out_busy;
    } t_stat;

endpackage

// ----- hw/rtl/otq_datapath.sv -----
`timescale 1ns / 1ps
module otq_datapath #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  otq_pkg::t_in                       i_data,
    input  otq_pkg::t_cmd                      i_cmd,
    input  logic                               i_out_ready,
    output otq_pkg::t_stat                     o_stat,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]   o_exp_cnt,
    output logic                               o_out_valid,
    output otq_pkg::t_out                      o_out
);
    localparam int D  = TABLE_DEPTH;
    localparam int CW = $clog2(D + 1);
    localparam int IW = $clog2(D);
    localparam int IdW = (ID_BITS < 8) ? ID_BITS : 8;

    otq_pkg::t_in   r_in;
    logic [D-1:0]   r_valid, n_valid;
    logic [32:0]    r_exp [D];
    logic [32:0]    n_exp [D];
    logic [IdW-1:0] r_id [D];
    logic [IdW-1:0] n_id [D];
    logic [32:0]    r_sleep;
    logic           r_empty;
    logic           r_out_valid;
    otq_pkg::t_out  r_out;

    logic [32:0]    now33, add_exp;
    logic [D-1:0]   le, eq, first, ge, expd;
    logic [CW-1:0]  cnt;
    logic [IW-1:0]  sidx;
    logic           s_empty;
    logic [32:0]    s_exp;

    assign now33   = {1'b0, r_in.now_ms};
    assign add_exp = now33 + {9'd0, r_in.delay_ms};

    always_comb begin
        cnt = '0;
        for (int i = 0; i < D; i++) begin
            le[i]   = r_valid[i] && (r_exp[i] <= add_exp);
            eq[i]   = r_valid[i] && (r_exp[i] == r_in.del_expire);
            expd[i] = r_valid[i] && (r_exp[i] <= now33);
            cnt     = cnt + CW'(expd[i]);
        end
        for (int i = 0; i < D; i++) begin
            first[i] = eq[i] && ((i == 0) || !eq[(i == 0) ? 0 : i - 1]);
            ge[i]    = first[i] || ((i != 0) && ge[(i == 0) ? 0 : i - 1]);
        end
    end

    assign o_exp_cnt       = cnt;
    assign o_stat.full     = r_valid[D-1];
    assign o_stat.any_match = |eq;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    // Sleep source: head of the table, or the first entry past the expired prefix.
    always_comb begin
        sidx    = '0;
        s_empty = !r_valid[0];
        if (i_cmd.sleep_at_cnt) begin
            if (cnt >= CW'(D)) begin
                s_empty = 1'b1;
            end else begin
                sidx    = cnt[IW-1:0];
                s_empty = !r_valid[sidx];
            end
        end
        s_exp = r_exp[sidx];
    end

    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < D; i++) begin
            n_exp[i] = r_exp[i];
            n_id[i]  = r_id[i];
        end
        if (i_cmd.do_add) begin
            n_valid = r_valid | {r_valid[D-2:0], 1'b1};
            for (int i = 0; i < D; i++) begin
                if (!le[i]) begin
                    if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
                        n_exp[i] = add_exp;
                        n_id[i]  = r_in.timer_id[IdW-1:0];
                    end else begin
                        n_exp[i] = r_exp[(i == 0) ? 0 : i - 1];
                        n_id[i]  = r_id[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end else if (i_cmd.del_step || i_cmd.pop) begin
            for (int i = 0; i < D; i++) begin
                if (i_cmd.pop || ge[i]) begin
                    if (i < D - 1) begin
                        n_exp[i]   = r_exp[(i < D - 1) ? i + 1 : i];
                        n_id[i]    = r_id[(i < D - 1) ? i + 1 : i];
                        n_valid[i] = r_valid[(i < D - 1) ? i + 1 : i];
                    end else begin
                        n_valid[i] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        for (int i = 0; i < D; i++) begin
            r_exp[i] <= n_exp[i];
            r_id[i]  <= n_id[i];
        end
        if (i_cmd.load_in) begin
            r_in <= i_data;
        end
        if (i_cmd.calc_sleep) begin
            r_empty <= s_empty;
            r_sleep <= (!s_empty && s_exp > now33) ? s_exp - now33 : 33'd0;
        end
        if (i_cmd.out_load) begin
            r_out.status       <= i_cmd.out_status;
            r_out.fired_id     <= i_cmd.out_fired ? 8'(r_id[0]) : 8'd0;
            r_out.fired_expire <= i_cmd.out_fired ? r_exp[0] : 33'd0;
            r_out.sleep_ms     <= r_sleep;
            r_out.queue_empty  <= r_empty;
            r_out.last         <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, r_valid} + 1'b1))
        else $error("valid slots do not form a prefix");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_add |=> $countones(r_valid) == $countones($past(r_valid)) + 1)
        else $error("insert did not grow the table by one");

    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_valid[0] && expd[0])
        else $error("pop of an entry that has not expired");
endmodule

// ----- hw/rtl/otq_ctrl.sv -----
`timescale 1ns / 1ps
module otq_ctrl #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [1:0]                         i_mode,
    input  otq_pkg::t_stat                     i_stat,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]   i_exp_cnt,
    output logic                               o_ready,
    output otq_pkg::t_cmd                      o_cmd
);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_ADD, S_DEL, S_SLP, S_HPREP, S_EMIT, S_HPOP} t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic [2:0]    r_status;
    logic          r_found;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load_in    = (r_state == S_IDLE) && i_valid;
        case (r_state)
            S_ADD:   o_cmd.do_add   = !i_stat.full;
            S_DEL:   o_cmd.del_step = i_stat.any_match;
            S_SLP:   o_cmd.calc_sleep = 1'b1;
            S_HPREP: begin
                o_cmd.calc_sleep   = 1'b1;
                o_cmd.sleep_at_cnt = 1'b1;
            end
            S_EMIT: begin
                o_cmd.out_load   = !i_stat.out_busy;
                o_cmd.out_status = r_status;
                o_cmd.out_last   = 1'b1;
            end
            S_HPOP: begin
                o_cmd.out_load   = !i_stat.out_busy;
                o_cmd.pop        = !i_stat.out_busy;
                o_cmd.out_status = otq_pkg::ST_EXPIRED;
                o_cmd.out_fired  = 1'b1;
                o_cmd.out_last   = (r_cnt == CW'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_status <= otq_pkg::ST_OK;
            r_found  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_found  <= 1'b0;
                        r_status <= otq_pkg::ST_OK;
                        case (i_mode)
                            otq_pkg::MODE_ADD:    r_state <= S_ADD;
                            otq_pkg::MODE_DEL:    r_state <= S_DEL;
                            otq_pkg::MODE_HANDLE: r_state <= S_HPREP;
                            default:              r_state <= S_SLP;
                        endcase
                    end
                end
                S_ADD: begin
                    r_status <= i_stat.full ? otq_pkg::ST_FULL : otq_pkg::ST_OK;
                    r_state  <= S_SLP;
                end
                S_DEL: begin
                    if (i_stat.any_match) begin
                        r_found <= 1'b1;
                    end else begin
                        r_status <= r_found ? otq_pkg::ST_OK : otq_pkg::ST_NOTFOUND;
                        r_state  <= S_SLP;
                    end
                end
                S_SLP: r_state <= S_EMIT;
                S_HPREP: begin
                    r_cnt <= i_exp_cnt;
                    if (i_exp_cnt == '0) begin
                        r_status <= otq_pkg::ST_NONE;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= S_HPOP;
                    end
                end
                S_EMIT: begin
                    if (!i_stat.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_HPOP: begin
                    if (!i_stat.out_busy) begin
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HPOP |-> r_cnt != '0)
        else $error("expired walk with zero count");

    a_onepop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |-> o_cmd.out_load)
        else $error("entry removed without a result");

    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.out_last) |=> r_state == S_IDLE)
        else $error("final result not followed by idle");
endmodule

// ----- hw/rtl/ordered_timer_queue.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_data  (otq_pkg::t_in)
// result    out        o_valid / i_ready  o_data  (otq_pkg::t_out)
//
// One item is worked at a time; o_ready is high only while the controller is idle.
// Add: insert, sleep, emit. Delete: one step per removed entry (the table shifts
// one matching entry per cycle), then sleep and emit. Handle: a single result when
// nothing has expired, otherwise one result per expired entry, which leave the
// table one per result transfer. Other modes: sleep, then emit.
// Reset is synchronous and active low; it empties the table.
// A stalled result transfer holds the sequencer in place; nothing is dropped.
module ordered_timer_queue #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  otq_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output otq_pkg::t_out o_data
);
    // The table lives in the datapath as a sorted register file; the controller
    // sequences insert, per-cycle delete steps, the sleep computation and the
    // walk that emits expired entries from the head of the table.
    otq_pkg::t_cmd                     cmd;
    otq_pkg::t_stat                    stat;
    logic [$clog2(TABLE_DEPTH+1)-1:0]  exp_cnt;

    otq_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_mode    (i_data.mode),
        .i_stat    (stat),
        .i_exp_cnt (exp_cnt),
        .o_ready   (o_ready),
        .o_cmd     (cmd)
    );

    otq_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .ID_BITS(ID_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_data),
        .i_cmd       (cmd),
        .i_out_ready (i_ready),
        .o_stat      (stat),
        .o_exp_cnt   (exp_cnt),
        .o_out_valid (o_valid),
        .o_out       (o_data)
    );
endmodule

// ----- verif/ordered_timer_queue_test.sv -----
`timescale 1ns / 1ps
module ordered_timer_queue_test;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    otq_pkg::t_in   i_data;
    logic           o_valid;
    logic           i_ready;
    otq_pkg::t_out  o_data;

    ordered_timer_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow of the timer table, kept sorted by expiry like the block's own.
    int          tbl_count;
    logic [32:0] tbl_expire [DEPTH];
    logic [7:0]  tbl_id     [DEPTH];

    otq_pkg::t_in   pending_ops [$];
    otq_pkg::t_out  expected_results [$];
    int    error_count;
    int    result_count;
    int    cycle_count = 0;
    int    op_count;
    int    fired_count;
    int    full_count;
    bit    hold_results;
    bit    pause_sender;
    int    send_gap;
    int    recv_gap;

    // A gap length, mostly short with the occasional long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_expire[i] = tbl_expire[i + 1];
            tbl_id[i] = tbl_id[i + 1];
        end
        tbl_count--;
    endfunction

    // Computes every result that one accepted operation causes, in order.
    function automatic void predict_timer_op(otq_pkg::t_in op);
        otq_pkg::t_out res [$];
        otq_pkg::t_out r;
        logic [32:0]   exp_time;
        logic [32:0]   now33;
        int            pos;
        bit            found;
        now33 = {1'b0, op.now_ms};
        r = '0;
        case (op.mode)
            otq_pkg::MODE_ADD: begin
                if (tbl_count >= DEPTH) begin
                    r.status = otq_pkg::ST_FULL;
                    full_count++;
                end else begin
                    exp_time = now33 + {9'd0, op.delay_ms};
                    pos = 0;
                    while (pos < tbl_count && tbl_expire[pos] <= exp_time) pos++;
                    for (int i = tbl_count; i > pos; i--) begin
                        tbl_expire[i] = tbl_expire[i - 1];
                        tbl_id[i] = tbl_id[i - 1];
                    end
                    tbl_expire[pos] = exp_time;
                    tbl_id[pos] = op.timer_id;
                    tbl_count++;
                    r.status = otq_pkg::ST_OK;
                end
                res.push_back(r);
            end
            otq_pkg::MODE_DEL: begin
                found = 1'b0;
                pos = 0;
                while (pos < tbl_count) begin
                    if (tbl_expire[pos] == op.del_expire) begin
                        drop_slot(pos);
                        found = 1'b1;
                    end else begin
                        pos++;
                    end
                end
                r.status = found ? otq_pkg::ST_OK : otq_pkg::ST_NOTFOUND;
                res.push_back(r);
            end
            otq_pkg::MODE_HANDLE: begin
                while (tbl_count > 0 && tbl_expire[0] <= now33) begin
                    r.status = otq_pkg::ST_EXPIRED;
                    r.fired_id = tbl_id[0];
                    r.fired_expire = tbl_expire[0];
                    res.push_back(r);
                    drop_slot(0);
                    fired_count++;
                end
                if (res.size() == 0) begin
                    r.status = otq_pkg::ST_NONE;
                    res.push_back(r);
                end
            end
            default: begin
                r.status = otq_pkg::ST_OK;
                res.push_back(r);
            end
        endcase
        // Sleep and empty reflect the table after the whole operation.
        foreach (res[j]) begin
            res[j].queue_empty = (tbl_count == 0);
            res[j].sleep_ms = (tbl_count > 0 && tbl_expire[0] > now33) ?
                              tbl_expire[0] - now33 : 33'd0;
            res[j].last = (j == res.size() - 1);
            expected_results.push_back(res[j]);
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
                 result_count, what, got, want);
        error_count++;
    endtask

    // Driver: presents queued operations with random gaps between transfers.
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data <= '0;
            send_gap <= 0;
        end else if (i_valid && o_ready) begin
            predict_timer_op(i_data);
            op_count++;
            gap = pick_gap();
            send_gap <= gap;
            if (gap == 0 && pending_ops.size() > 0 && !pause_sender) begin
                i_data <= pending_ops.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_ops.size() > 0 && !pause_sender) begin
                i_data <= pending_ops.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    // Monitor: checks every result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        otq_pkg::t_out want;
        int            gap;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result status", 64'(o_data.status), 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_data.status !== want.status)
                        report_mismatch("status", 64'(o_data.status), 64'(want.status));
                    if (o_data.fired_id !== want.fired_id)
                        report_mismatch("fired_id", 64'(o_data.fired_id),
                                        64'(want.fired_id));
                    if (o_data.fired_expire !== want.fired_expire)
                        report_mismatch("fired_expire", 64'(o_data.fired_expire),
                                        64'(want.fired_expire));
                    if (o_data.sleep_ms !== want.sleep_ms)
                        report_mismatch("sleep_ms", 64'(o_data.sleep_ms),
                                        64'(want.sleep_ms));
                    if (o_data.queue_empty !== want.queue_empty)
                        report_mismatch("queue_empty", 64'(o_data.queue_empty),
                                        64'(want.queue_empty));
                    if (o_data.last !== want.last)
                        report_mismatch("last", 64'(o_data.last), 64'(want.last));
                end
                result_count++;
            end
            if (hold_results) begin
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else if (o_valid && i_ready) begin
                gap = pick_gap();
                recv_gap <= gap;
                i_ready <= (gap == 0);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic otq_pkg::t_in make_op(logic [1:0] mode, logic [31:0] now,
                                             logic [23:0] delay, logic [7:0] id,
                                             logic [32:0] dexp);
        otq_pkg::t_in op;
        op.mode = mode;
        op.now_ms = now;
        op.delay_ms = delay;
        op.timer_id = id;
        op.del_expire = dexp;
        return op;
    endfunction

    // Random operation around a slowly advancing clock so that expiries
    // collide, hit exactly and expire in useful numbers.
    function automatic otq_pkg::t_in random_op(ref logic [31:0] clock_ms);
        int          r;
        logic [1:0]  mode;
        logic [23:0] delay;
        logic [32:0] dexp;
        r = $urandom_range(0, 99);
        if (r < 50) mode = otq_pkg::MODE_ADD;
        else if (r < 65) mode = otq_pkg::MODE_DEL;
        else if (r < 95) mode = otq_pkg::MODE_HANDLE;
        else mode = MODE_SPARE;
        clock_ms = clock_ms + $urandom_range(0, 12);
        if ($urandom_range(0, 19) == 0) delay = 24'($urandom());
        else delay = 24'($urandom_range(0, 40));
        if ($urandom_range(0, 4) == 0) dexp = 33'({$urandom(), $urandom()});
        else dexp = {1'b0, clock_ms} + 33'($urandom_range(0, 40));
        return make_op(mode, clock_ms, delay, 8'($urandom()), dexp);
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] clock_ms;
        i_rst_n = 1'b0;
        tbl_count = 0;
        error_count = 0;
        result_count = 0;
        op_count = 0;
        fired_count = 0;
        full_count = 0;
        hold_results = 1'b0;
        pause_sender = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty handle, extremes, every mode, a full table,
        // equal expiries, matched and unmatched deletes, spare mode.
        pending_ops.push_back(make_op(otq_pkg::MODE_HANDLE, 32'd0, 24'd0, 8'd0, 33'd0));
        pending_ops.push_back(make_op(otq_pkg::MODE_ADD, 32'hFFFF_FFFF, 24'hFF_FFFF,
                                      8'hFF, 33'd0));
        pending_ops.push_back(make_op(otq_pkg::MODE_DEL, 32'd0, 24'd0, 8'd0,
                                      33'h1_00FF_FFFE));
        pending_ops.push_back(make_op(otq_pkg::MODE_DEL, 32'hFFFF_FFFF, 24'hFF_FFFF,
                                      8'hFF, 33'h1_FFFF_FFFF));
        pending_ops.push_back(make_op(MODE_SPARE, 32'h5555_5555, 24'hAA_AAAA, 8'h55,
                                      33'h0_AAAA_AAAA));
        for (int i = 0; i < 17; i++)
            pending_ops.push_back(make_op(otq_pkg::MODE_ADD, 32'd100, 24'(i % 3),
                                          8'(i), 33'd0));
        pending_ops.push_back(make_op(otq_pkg::MODE_DEL, 32'd100, 24'd0, 8'd0, 33'd101));
        pending_ops.push_back(make_op(otq_pkg::MODE_HANDLE, 32'd102, 24'd0, 8'd0, 33'd0));
        pending_ops.push_back(make_op(otq_pkg::MODE_HANDLE, 32'd102, 24'd0, 8'd0, 33'd0));
        wait_drained();

        // Receiver holds off while the sender keeps offering items.
        clock_ms = 32'd1000;
        hold_results = 1'b1;
        for (int i = 0; i < 20; i++) pending_ops.push_back(random_op(clock_ms));
        repeat (300) @(posedge i_clk);
        hold_results = 1'b0;
        wait_drained();

        // Random traffic, with one pause until all results are back.
        for (int i = 0; i < 164; i++) begin
            pending_ops.push_back(random_op(clock_ms));
            if (i == 82) begin
                wait_drained();
                pause_sender = 1'b1;
                repeat (50) @(posedge i_clk);
                pause_sender = 1'b0;
            end
        end
        // Flush with a late handle that expires every timer due by then.
        clock_ms = clock_ms + 32'd100000;
        pending_ops.push_back(make_op(otq_pkg::MODE_HANDLE, clock_ms, 24'd0, 8'd0, 33'd0));
        wait_drained();

        $display("Covered %0d operations, %0d results, %0d expired timers, %0d full adds.",
                 op_count, result_count, fired_count, full_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/otq_pkg.sv
hw/rtl/otq_datapath.sv
hw/rtl/otq_ctrl.sv
hw/rtl/ordered_timer_queue.sv
verif/ordered_timer_queue_test.sv
